### rtl/core/pct_pkg.sv
package pct_pkg;

    // Controller states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } pct_state_t;

    // Request kinds carried in s_axis_tuser[0]
    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam int KEY_W   = 16;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 4;
    localparam int USED_W  = 5;

    // Memory access command
    typedef struct packed
    {
        logic rd;
        logic key_we;
        logic cnt_we;
    } pct_mem_cmd_t;

    // One result word
    typedef struct packed
    {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   entry_key;
        logic [COUNT_W-1:0] entry_count;
        logic               table_full;
        logic [USED_W-1:0]  entries_used;
    } pct_result_t;

endpackage

### rtl/core/protocol_count_table_top.sv
// Per-key packet counter tables: one keyed by EtherType, one by IP protocol.
// Input words arrive on s_axis: tuser selects count or read and the table,
// tdata carries the keys and the slot to read. Each accepted word gives
// exactly one result word on m_axis (hit and table_full in tuser).
// A count request scans the keys of the addressed table in memory, one entry
// per cycle, then bumps the matching counter (saturating at all ones) or
// appends the key with count one; a full table drops the key and flags it.
// A read request reads the addressed slot and registers its result; a count
// request ends its scan at the matching key, or once every entry in use is
// compared, at once on an empty table. The single-port key and counter
// memories are read one entry a cycle during the scan. One word is handled
// at a time: s_axis_tready rises again once the result has moved into the
// output register, so the next word is taken while that result still waits.
// Reset clears the in-use counts of both tables; the memories need no clear.
// When m_axis_tready is low the result holds in the output register and a
// second finished result waits in the controller, stalling further input.
module protocol_count_table_top
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // ethertype[15:0], ip_protocol[23:16], read_slot[27:24]
    input  logic [1:0]  s_axis_tuser,   // req_type[0], use_ip_table[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // slot[3:0], entry_key[19:4], entry_count[51:20],
                                        // entries_used[56:52]
    output logic [1:0]  m_axis_tuser    // hit[0], table_full[1]
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int AW = IW + 1;

    pct_pkg::pct_mem_cmd_t       mem_cmd;
    logic [AW-1:0]               mem_addr;
    logic [pct_pkg::KEY_W-1:0]   wkey;
    logic [pct_pkg::COUNT_W-1:0] wcnt;
    logic [pct_pkg::KEY_W-1:0]   key_q;
    logic [pct_pkg::COUNT_W-1:0] cnt_q;
    logic                        res_valid;
    logic                        res_ready;
    pct_pkg::pct_result_t        res;

    logic                        out_valid_reg, out_valid_next;
    pct_pkg::pct_result_t        out_res_reg, out_res_next;

    pct_ctrl
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .req_type     (s_axis_tuser[0]),
        .use_ip_table (s_axis_tuser[1]),
        .ethertype    (s_axis_tdata[15:0]),
        .ip_protocol  (s_axis_tdata[23:16]),
        .read_slot    (s_axis_tdata[27:24]),
        .key_q        (key_q),
        .cnt_q        (cnt_q),
        .mem_cmd      (mem_cmd),
        .mem_addr     (mem_addr),
        .wkey         (wkey),
        .wcnt         (wcnt),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    pct_mem
    #(
        .AW (AW)
    )
    u_mem
    (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wkey  (wkey),
        .wcnt  (wcnt),
        .key_q (key_q),
        .cnt_q (cnt_q)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // Pack the result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.entries_used,
                            out_res_reg.entry_count,
                            out_res_reg.entry_key,
                            out_res_reg.slot};
    assign m_axis_tuser  = {out_res_reg.table_full, out_res_reg.hit};

    // A finished result holds until the output register takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while waiting for the output register");

    // Input is taken only with no result pending in the controller
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !res_valid)
    else $error("input accepted while a result is pending");

    // A dropped key reports no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.table_full |-> !res.hit && res.entry_count == '0)
    else $error("full-table result carries entry data");

    // A hit entry always has a nonzero counter
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.hit |-> res.entry_count != '0 && !res.table_full)
    else $error("hit result with zero counter");

endmodule

### rtl/core/pct_mem.sv
module pct_mem
#(
    parameter int AW = 5
)
(
    input  logic                          clk,
    input  pct_pkg::pct_mem_cmd_t         cmd,
    input  logic [AW-1:0]                 addr,
    input  logic [pct_pkg::KEY_W-1:0]     wkey,
    input  logic [pct_pkg::COUNT_W-1:0]   wcnt,
    output logic [pct_pkg::KEY_W-1:0]     key_q,
    output logic [pct_pkg::COUNT_W-1:0]   cnt_q
);

    localparam int DEPTH = 1 << AW;

    logic [pct_pkg::KEY_W-1:0]   key_mem [DEPTH];
    logic [pct_pkg::COUNT_W-1:0] cnt_mem [DEPTH];

    // Key store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.key_we)
        begin
            key_mem[addr] <= wkey;
        end
        if (cmd.rd)
        begin
            key_q <= key_mem[addr];
        end
    end

    // Counter store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_we)
        begin
            cnt_mem[addr] <= wcnt;
        end
        if (cmd.rd)
        begin
            cnt_q <= cnt_mem[addr];
        end
    end

endmodule

### rtl/core/pct_ctrl.sv
module pct_ctrl
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       req_type,
    input  logic                                       use_ip_table,
    input  logic [15:0]                                ethertype,
    input  logic [7:0]                                 ip_protocol,
    input  logic [3:0]                                 read_slot,
    input  logic [pct_pkg::KEY_W-1:0]                  key_q,
    input  logic [pct_pkg::COUNT_W-1:0]                cnt_q,
    output pct_pkg::pct_mem_cmd_t                      mem_cmd,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1):0] mem_addr,
    output logic [pct_pkg::KEY_W-1:0]                  wkey,
    output logic [pct_pkg::COUNT_W-1:0]                wcnt,
    output logic                                       res_valid,
    input  logic                                       res_ready,
    output pct_pkg::pct_result_t                       res
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW = $clog2(TABLE_DEPTH + 1);

    pct_pkg::pct_state_t state_reg, state_next;

    logic                        tab_reg, tab_next;
    logic [pct_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [3:0]                  rs_reg, rs_next;
    logic [UW-1:0]               issue_reg, issue_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [UW-1:0]               link_used_reg, link_used_next;
    logic [UW-1:0]               ip_used_reg, ip_used_next;
    pct_pkg::pct_result_t        res_reg, res_next;

    logic [UW-1:0]               n;
    logic [31:0]                 n_ext;
    logic [31:0]                 issue_ext;
    logic [31:0]                 rs_ext;
    logic [31:0]                 cmp_ext;
    logic [31:0]                 rs_in_ext;
    logic [pct_pkg::KEY_W-1:0]   in_key;
    logic                        issue_more;
    logic                        scan_hit;
    logic                        scan_miss;
    logic                        tab_is_full;
    logic                        rs_in_use;
    logic [pct_pkg::COUNT_W-1:0] cnt_inc;

    // Entries in use of the addressed table
    assign n          = tab_reg ? ip_used_reg : link_used_reg;
    assign n_ext      = 32'(n);
    assign issue_ext  = 32'(issue_reg);
    assign rs_ext     = 32'(rs_reg);
    assign cmp_ext    = 32'(cmp_idx_reg);
    assign rs_in_ext  = 32'(read_slot);
    assign in_key     = use_ip_table ? {8'h00, ip_protocol} : ethertype;

    // Scan status
    assign issue_more  = issue_ext < n_ext;
    assign scan_hit    = cmp_valid_reg && (key_q == key_reg);
    assign scan_miss   = !cmp_valid_reg && !issue_more;
    assign tab_is_full = n_ext >= 32'(TABLE_DEPTH);
    assign rs_in_use   = rs_ext < n_ext;
    assign cnt_inc     = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pct_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == pct_pkg::REQ_READ) ? pct_pkg::ST_READ
                                                                 : pct_pkg::ST_SCAN;
                end
            end
            pct_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = pct_pkg::ST_DONE;
                end
            end
            pct_pkg::ST_READ:
            begin
                state_next = pct_pkg::ST_DONE;
            end
            pct_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = pct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pct_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and memory access
    always_comb
    begin
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_cmd    = '0;
        mem_addr   = {tab_reg, issue_ext[IW-1:0]};
        wkey       = key_reg;
        wcnt       = scan_hit ? cnt_inc : 32'd1;
        case (state_reg)
            pct_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (req_type == pct_pkg::REQ_READ))
                begin
                    mem_cmd.rd = 1'b1;
                    mem_addr   = {use_ip_table, rs_in_ext[IW-1:0]};
                end
            end
            pct_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    // write back the bumped counter
                    mem_cmd.cnt_we = 1'b1;
                    mem_addr       = {tab_reg, cmp_idx_reg};
                end
                else if (scan_miss)
                begin
                    // append the new key unless the table is full
                    if (!tab_is_full)
                    begin
                        mem_cmd.key_we = 1'b1;
                        mem_cmd.cnt_we = 1'b1;
                        mem_addr       = {tab_reg, n_ext[IW-1:0]};
                    end
                end
                else if (issue_more)
                begin
                    mem_cmd.rd = 1'b1;
                end
            end
            pct_pkg::ST_READ:
            begin
                mem_cmd = '0;
            end
            pct_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                mem_cmd = '0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        tab_next       = tab_reg;
        key_next       = key_reg;
        rs_next        = rs_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        link_used_next = link_used_reg;
        ip_used_next   = ip_used_reg;
        res_next       = res_reg;
        case (state_reg)
            pct_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    tab_next   = use_ip_table;
                    key_next   = in_key;
                    rs_next    = read_slot;
                    issue_next = '0;
                end
            end
            pct_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_next.hit          = 1'b1;
                    res_next.slot         = cmp_ext[pct_pkg::SLOT_W-1:0];
                    res_next.entry_key    = key_q;
                    res_next.entry_count  = cnt_inc;
                    res_next.table_full   = 1'b0;
                    res_next.entries_used = n_ext[pct_pkg::USED_W-1:0];
                end
                else if (scan_miss)
                begin
                    if (tab_is_full)
                    begin
                        res_next.hit          = 1'b0;
                        res_next.slot         = '0;
                        res_next.entry_key    = '0;
                        res_next.entry_count  = '0;
                        res_next.table_full   = 1'b1;
                        res_next.entries_used = n_ext[pct_pkg::USED_W-1:0];
                    end
                    else
                    begin
                        res_next.hit          = 1'b0;
                        res_next.slot         = n_ext[pct_pkg::SLOT_W-1:0];
                        res_next.entry_key    = key_reg;
                        res_next.entry_count  = 32'd1;
                        res_next.table_full   = 1'b0;
                        res_next.entries_used = 5'(n_ext + 32'd1);
                        if (tab_reg)
                        begin
                            ip_used_next = n + UW'(1);
                        end
                        else
                        begin
                            link_used_next = n + UW'(1);
                        end
                    end
                end
                else if (issue_more)
                begin
                    // advance the scan, compare next cycle
                    issue_next     = issue_reg + UW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_ext[IW-1:0];
                end
            end
            pct_pkg::ST_READ:
            begin
                res_next.hit          = rs_in_use;
                res_next.slot         = rs_reg;
                res_next.entry_key    = rs_in_use ? key_q : '0;
                res_next.entry_count  = rs_in_use ? cnt_q : '0;
                res_next.table_full   = 1'b0;
                res_next.entries_used = n_ext[pct_pkg::USED_W-1:0];
            end
            pct_pkg::ST_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pct_pkg::ST_IDLE;
            cmp_valid_reg <= 1'b0;
            link_used_reg <= '0;
            ip_used_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            link_used_reg <= link_used_next;
            ip_used_reg   <= ip_used_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tab_reg     <= tab_next;
        key_reg     <= key_next;
        rs_reg      <= rs_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule
